@@ hw/rtl/sssb_pkg.sv @@
`timescale 1ns / 1ps

package sssb_pkg;

  localparam int unsigned DIGIT_COUNT = 4;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned SEG_W = 8;
  localparam int unsigned SEL_W = 4;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned TICK_W = 8;
  localparam int unsigned BLINK_W = 3;

  localparam logic [TICK_W-1:0] TICKS_RESET = 8'd10;
  localparam logic [SEL_W-1:0] SEL_ALL_OFF = 4'hF;
  localparam logic [SEG_W-1:0] SEG_RESET = 8'hFF;
  localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd7;
  localparam logic [BLINK_W-1:0] BLINK_NONE = 3'd0;
  localparam logic [BLINK_W-1:0] BLINK_MAX = 3'd4;

  typedef struct packed {
    logic known;
    logic [SEG_W-1:0] pattern;
  } seg_dec_t;

endpackage

@@ hw/rtl/sssb_seg_decode.sv @@
`timescale 1ns / 1ps

module sssb_seg_decode
  import sssb_pkg::*;
(
  input  logic [CHAR_W-1:0] char_in,
  output seg_dec_t          dec
);

  always_comb begin
    dec.known = 1'b1;
    case (char_in)
      "0":     dec.pattern = 8'h12;
      "1":     dec.pattern = 8'h77;
      "2":     dec.pattern = 8'h2A;
      "3":     dec.pattern = 8'h26;
      "4":     dec.pattern = 8'h47;
      "5":     dec.pattern = 8'h86;
      "6":     dec.pattern = 8'h82;
      "7":     dec.pattern = 8'h37;
      "8":     dec.pattern = 8'h02;
      "9":     dec.pattern = 8'h06;
      "A":     dec.pattern = 8'h03;
      "B":     dec.pattern = 8'hC2;
      "C":     dec.pattern = 8'h9A;
      "D":     dec.pattern = 8'h62;
      "E":     dec.pattern = 8'h8A;
      "F":     dec.pattern = 8'h8B;
      "H":     dec.pattern = 8'h43;
      "L":     dec.pattern = 8'hDA;
      "n":     dec.pattern = 8'h13;
      "u":     dec.pattern = 8'h52;
      "p":     dec.pattern = 8'h0B;
      "o":     dec.pattern = 8'hE2;
      "-":     dec.pattern = 8'hEF;
      "*":     dec.pattern = 8'hFF;
      "y":     dec.pattern = 8'h46;
      default: begin
        dec.known   = 1'b0;
        dec.pattern = SEG_RESET;
      end
    endcase
  end

endmodule

@@ hw/rtl/seven_segment_scan_blink.sv @@
`timescale 1ns / 1ps
// An accepted item is held in the input register, then the scan state and
// result register are updated together when the output can advance.
// Throughput: one item per cycle while the output is not stalled; the scan
// counter and phase close their loop through their own registers alone.
// Reset (rst_n low, synchronous): pipeline empty, tick count and phase zero,
// segments 0xFF, selects all off, ticks_per_phase 10.

module seven_segment_scan_blink
  import sssb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // ticks_per_phase
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // digit0_char, digit1_char, digit2_char,
                                     // digit3_char, blink_code, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata      // segment_pattern, digit_select, zero pad
);

  logic                         s1_valid_r;
  logic [DIGIT_COUNT*CHAR_W-1:0] s1_chars_r;
  logic [BLINK_W-1:0]           s1_blink_r;
  logic                         out_valid_r;

  logic [TICK_W-1:0]  tpp_r;
  logic [TICK_W-1:0]  tick_r, tick_nxt, tick_inc;
  logic [PHASE_W-1:0] phase_r, phase_nxt, phase_cur;
  logic [SEG_W-1:0]   seg_r, seg_nxt;
  logic [SEL_W-1:0]   sel_r, sel_nxt;

  logic               advance;
  logic               fire;
  logic [1:0]         pos;
  logic               blank_en;
  logic [1:0]         blank_pos;
  logic [CHAR_W-1:0]  cur_char;
  seg_dec_t           dec;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tpp_r       <= TICKS_RESET;
      tick_r      <= '0;
      phase_r     <= '0;
      seg_r       <= SEG_RESET;
      sel_r       <= SEL_ALL_OFF;
    end else begin
      if (cfg_wr_en) begin
        tpp_r <= cfg_wr_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        tick_r  <= tick_nxt;
        phase_r <= phase_nxt;
        seg_r   <= seg_nxt;
        sel_r   <= sel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_chars_r <= in_tdata[DIGIT_COUNT*CHAR_W-1:0];
      s1_blink_r <= in_tdata[DIGIT_COUNT*CHAR_W +: BLINK_W];
    end
  end

  always_comb begin
    tick_inc  = tick_r + 8'd1;
    tick_nxt  = tick_inc;
    phase_cur = phase_r;
    if (tick_inc == tpp_r) begin
      tick_nxt  = '0;
      phase_cur = phase_r + 3'd1;
    end
  end

  assign pos       = phase_cur[2:1];
  assign blank_en  = (s1_blink_r != BLINK_NONE) && (s1_blink_r <= BLINK_MAX);
  assign blank_pos = 2'(BLINK_MAX - s1_blink_r);
  assign cur_char  = s1_chars_r[pos*CHAR_W +: CHAR_W];

  sssb_seg_decode u_dec (
    .char_in (cur_char),
    .dec     (dec)
  );

  always_comb begin
    phase_nxt = phase_cur;
    seg_nxt   = seg_r;
    sel_nxt   = SEL_ALL_OFF;
    if (phase_cur == PHASE_LAST) begin
      phase_nxt = '0;
    end else if (!phase_cur[0] && !(blank_en && (pos == blank_pos))) begin
      sel_nxt = ~(SEL_W'(1) << pos);
      if (dec.known) begin
        seg_nxt = dec.pattern;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, sel_r, seg_r};

  a_phase_never_last: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PHASE_LAST)
    else $error("stored scan phase reached the wrap value");

  a_one_select: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(~sel_r) <= 1)
    else $error("more than one digit selected");

  a_select_even_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && sel_nxt != SEL_ALL_OFF) |-> !phase_nxt[0])
    else $error("digit selected in an odd phase");

  a_tick_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && phase_cur != phase_r) |=> tick_r == '0)
    else $error("tick count not restarted on phase advance");

endmodule

@@ tb/seven_segment_scan_blink_test.sv @@
`timescale 1ns / 1ps

module seven_segment_scan_blink_test;
  import sssb_pkg::*;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic [SEL_W-1:0] sel;
  } display_t;

  typedef enum int {RX_STEADY, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam string KNOWN_CHARS = "0123456789ABCDEFHLnupo-*y";

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // digit0_char, digit1_char, digit2_char, digit3_char,
                                // blink_code, zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // segment_pattern, digit_select, zero pad

  seven_segment_scan_blink dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  // scan state mirror
  logic [TICK_W-1:0]  period = TICKS_RESET;
  logic [TICK_W-1:0]  tick_cnt = '0;
  logic [PHASE_W-1:0] phase = '0;
  logic [SEG_W-1:0]   seg_latch = SEG_RESET;
  logic [SEL_W-1:0]   sel_latch = SEL_ALL_OFF;

  display_t expected_display[$];
  int mismatch_count = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int mode_left = 0;
  rx_mode_t rx_mode = RX_STEADY;

  logic [SEG_W-1:0] glyph [25] = '{
    8'h12, 8'h77, 8'h2A, 8'h26, 8'h47, 8'h86, 8'h82, 8'h37, 8'h02, 8'h06,
    8'h03, 8'hC2, 8'h9A, 8'h62, 8'h8A, 8'h8B,
    8'h43, 8'hDA, 8'h13, 8'h52, 8'h0B, 8'hE2, 8'hEF, 8'hFF, 8'h46
  };

  function automatic seg_dec_t decode_char(input logic [7:0] c);
    seg_dec_t d;
    int idx;
    idx = -1;
    if (c >= "0" && c <= "9") idx = c - "0";
    else if (c >= "A" && c <= "F") idx = c - "A" + 10;
    else begin
      case (c)
        "H": idx = 16;
        "L": idx = 17;
        "n": idx = 18;
        "u": idx = 19;
        "p": idx = 20;
        "o": idx = 21;
        "-": idx = 22;
        "*": idx = 23;
        "y": idx = 24;
        default: idx = -1;
      endcase
    end
    d.known = (idx >= 0);
    d.pattern = (idx >= 0) ? glyph[idx] : SEG_RESET;
    return d;
  endfunction

  function automatic display_t advance_scan(input logic [3:0][7:0] digits,
                                            input logic [BLINK_W-1:0] blink);
    display_t r;
    seg_dec_t d;
    int blank_pos;
    int pos;
    blank_pos = DIGIT_COUNT;
    if (blink != BLINK_NONE && blink <= BLINK_MAX) blank_pos = DIGIT_COUNT - blink;
    tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt == period) begin
      phase = phase + 1'b1;
      tick_cnt = '0;
    end
    if (phase == PHASE_LAST) begin
      sel_latch = SEL_ALL_OFF;
      phase = '0;
    end else if (phase[0]) begin
      sel_latch = SEL_ALL_OFF;
    end else begin
      pos = phase[2:1];
      if (pos == blank_pos) begin
        sel_latch = SEL_ALL_OFF;
      end else begin
        sel_latch = ~(SEL_W'(1) << pos);
        d = decode_char(digits[pos]);
        if (d.known) seg_latch = d.pattern;
      end
    end
    r.seg = seg_latch;
    r.sel = sel_latch;
    return r;
  endfunction

  task automatic send_tick(input logic [3:0][7:0] digits, input logic [BLINK_W-1:0] blink);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, blink, digits};
    do @(posedge clk); while (!in_tready);
    expected_display.push_back(advance_scan(digits, blink));
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 6) == 0) return 8'($urandom_range(0, 255));
    return KNOWN_CHARS[$urandom_range(0, KNOWN_CHARS.len() - 1)];
  endfunction

  task automatic send_random_ticks(input int n);
    logic [3:0][7:0] digits;
    logic [BLINK_W-1:0] blink;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < DIGIT_COUNT; k++) digits[k] = pick_char();
      blink = ($urandom_range(0, 2) == 0) ? BLINK_NONE : BLINK_W'($urandom_range(0, 7));
      send_tick(digits, blink);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_display.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [7:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    period = value;
  endtask

  task automatic test_reset_period();
    send_random_ticks(40);
    wait_idle();
  endtask

  task automatic test_decode_chars();
    logic [7:0] c;
    write_period(8'd2);
    for (int i = 0; i < KNOWN_CHARS.len() + 3; i++) begin
      if (i < KNOWN_CHARS.len()) c = KNOWN_CHARS[i];
      else c = (i == KNOWN_CHARS.len()) ? 8'h00 : (i == KNOWN_CHARS.len() + 1) ? 8'hFF : "z";
      send_tick({c, c, c, c}, BLINK_NONE);
    end
    wait_idle();
  endtask

  task automatic test_blink_codes();
    write_period(8'd1);
    for (int b = 0; b < 8; b++) send_tick({"3", "2", "1", "0"}, BLINK_W'(b));
    wait_idle();
  endtask

  task automatic test_zero_period();
    write_period(8'd0);
    send_random_ticks(300);
    wait_idle();
  endtask

  task automatic test_period_lowered();
    write_period(8'd255);
    send_random_ticks(100);
    wait_idle();
    write_period(8'd5);
    send_random_ticks(200);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    write_period(8'd1);
    hold_request = 1'b1;
    no_gaps = 1'b1;
    send_random_ticks(150);
    no_gaps = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_scan();
    logic [7:0] periods [8] = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd7, 8'd8, 8'd0, 8'd0};
    periods[6] = 8'($urandom_range(1, 12));
    periods[7] = 8'($urandom_range(1, 255));
    for (int p = 0; p < 8; p++) begin
      write_period(periods[p]);
      send_random_ticks(30);
      wait_idle();
    end
  endtask

  // result receiver: own stall pattern, plus a long hold on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (rx_mode)
        RX_STEADY: out_tready <= 1'b1;
        RX_HALF: out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    display_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_display.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 20)
          $display("%0t: unexpected item, expected none, actual %h", $time, out_tdata);
      end else begin
        want = expected_display.pop_front();
        if (out_tdata[7:0] !== want.seg) begin
          mismatch_count++;
          if (mismatch_count <= 20)
            $display("%0t: segment_pattern expected %h, actual %h",
                     $time, want.seg, out_tdata[7:0]);
        end
        if (out_tdata[11:8] !== want.sel) begin
          mismatch_count++;
          if (mismatch_count <= 20)
            $display("%0t: digit_select expected %h, actual %h",
                     $time, want.sel, out_tdata[11:8]);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_period();
    test_decode_chars();
    test_blink_codes();
    test_zero_period();
    test_period_lowered();
    test_output_backpressure();
    test_random_scan();
    repeat (10) @(posedge clk);
    if (expected_display.size() != 0) mismatch_count++;
    if (mismatch_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ seven_segment_scan_blink.f @@
hw/rtl/sssb_pkg.sv
hw/rtl/sssb_seg_decode.sv
hw/rtl/seven_segment_scan_blink.sv
tb/seven_segment_scan_blink_test.sv
